// ----- sv/rau_pkg.sv -----
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared widths and action codes.
// ----------------------------------------------------------------------------
package rau_pkg;
   localparam int OPERAND_WIDTH = 32;
   localparam int DEN_WIDTH     = OPERAND_WIDTH - 1;
   localparam int RES_WIDTH     = 64;
   localparam int RDEN_WIDTH    = 62;
   localparam int CNT_WIDTH     = 7;

   typedef enum logic [1:0] {
      ACT_ADD = 2'd0,
      ACT_SUB = 2'd1,
      ACT_MUL = 2'd2,
      ACT_DIV = 2'd3
   } action_type;
endpackage

// ----- sv/rational_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Adds, subtracts, multiplies or divides two fractions and reduces the result.
// ----------------------------------------------------------------------------
// Usage: an item on req_* is taken when req_valid is high and req_stall low.
// req_stall stays high from acceptance until the result item has been taken
// from rsp_*, so one item is in flight at a time.
// The cross products are formed on one 33x33 signed multiplier, one product a
// cycle, and for add and subtract summed. The magnitudes are then reduced by a
// single 64-bit restoring divider, one quotient bit per cycle: the Euclidean
// GCD takes one division per remainder step, followed by two exact divisions.
// Add and subtract form a third product (S_MUL2) that multiply and divide
// skip, and the time to rsp_valid grows with the number of GCD steps, most
// for Fibonacci-like operands.
// A zero denominator gives status 1 and 0/1 without a pass through the divider.
// The result holds on rsp_* while rsp_stall is high.
// Reset (synchronous, active high) returns the sequencer to idle and drops
// rsp_valid; an item in progress is lost.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_action,
   input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] req_a_numerator,
   input  logic [rau_pkg::DEN_WIDTH-1:0]        req_a_denominator,
   input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] req_b_numerator,
   input  logic [rau_pkg::DEN_WIDTH-1:0]        req_b_denominator,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [rau_pkg::RES_WIDTH-1:0] rsp_result_numerator,
   output logic [rau_pkg::RDEN_WIDTH-1:0]       rsp_result_denominator,
   output logic                                 rsp_status
);
   import rau_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_SIGN, S_GCD, S_DIVN, S_DIVD, S_DIV,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   state_type ret_ff, ret_in;
   logic [1:0] act_ff, act_in;
   logic signed [OPERAND_WIDTH-1:0] an_ff, an_in, bn_ff, bn_in;
   logic [DEN_WIDTH-1:0] ad_ff, ad_in, bd_ff, bd_in;
   logic signed [RES_WIDTH-1:0] p_ff, p_in;      // first product
   logic signed [RES_WIDTH-1:0] num_ff, num_in;
   logic signed [RES_WIDTH-1:0] den_ff, den_in;
   logic [RES_WIDTH-1:0] nm_ff, nm_in, dm_ff, dm_in, x_ff, x_in, y_ff, y_in;
   logic neg_ff, neg_in;
   // Shared divider: dividend shift register, remainder, divisor, count.
   logic [RES_WIDTH-1:0] q_ff, q_in, r_ff, r_in, dv_ff, dv_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic rv_ff, rv_in, st_ff, st_in;
   logic signed [RES_WIDTH-1:0] rn_ff, rn_in;
   logic [RDEN_WIDTH-1:0] rd_ff, rd_in;

   // Shared multiplier operands.
   logic signed [OPERAND_WIDTH:0] ma, mb;
   logic signed [2*OPERAND_WIDTH+1:0] mp;
   logic [RES_WIDTH:0] rsh, rsub;

   always_comb begin
      ma = '0;
      mb = '0;
      case (state_ff)
         S_MUL0: begin
            ma = {an_ff[OPERAND_WIDTH-1], an_ff};
            mb = (act_ff == ACT_MUL) ? {bn_ff[OPERAND_WIDTH-1], bn_ff}
                                      : {2'b00, bd_ff};
         end
         S_MUL1: begin
            ma = {2'b00, ad_ff};
            mb = (act_ff == ACT_DIV) ? {bn_ff[OPERAND_WIDTH-1], bn_ff}
                                      : {2'b00, bd_ff};
         end
         S_MUL2: begin
            ma = {bn_ff[OPERAND_WIDTH-1], bn_ff};
            mb = {2'b00, ad_ff};
         end
         default: begin
            ma = '0;
            mb = '0;
         end
      endcase
      mp = ma * mb;
      rsh = {r_ff, q_ff[RES_WIDTH-1]};
      rsub = rsh - {1'b0, dv_ff};
   end

   always_comb begin
      state_in = state_ff; ret_in = ret_ff; act_in = act_ff;
      an_in = an_ff; bn_in = bn_ff; ad_in = ad_ff; bd_in = bd_ff;
      p_in = p_ff; num_in = num_ff; den_in = den_ff;
      nm_in = nm_ff; dm_in = dm_ff; x_in = x_ff; y_in = y_ff; neg_in = neg_ff;
      q_in = q_ff; r_in = r_ff; dv_in = dv_ff; cnt_in = cnt_ff;
      rv_in = rv_ff; st_in = st_ff; rn_in = rn_ff; rd_in = rd_ff;
      if (rv_ff && !rsp_stall) begin
         rv_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            // A new item waits until the previous result has been taken.
            if (req_valid && !rv_ff) begin
               act_in = req_action;
               an_in = req_a_numerator; bn_in = req_b_numerator;
               ad_in = req_a_denominator; bd_in = req_b_denominator;
               state_in = S_MUL0;
            end
         end
         S_MUL0: begin
            p_in = RES_WIDTH'(mp);
            state_in = S_MUL1;
         end
         S_MUL1: begin
            den_in = RES_WIDTH'(mp);
            if (act_ff == ACT_MUL || act_ff == ACT_DIV) begin
               num_in = p_ff;
               state_in = S_SIGN;
            end else begin
               state_in = S_MUL2;
            end
         end
         S_MUL2: begin
            num_in = (act_ff == ACT_ADD) ? p_ff + RES_WIDTH'(mp)
                                         : p_ff - RES_WIDTH'(mp);
            state_in = S_SIGN;
         end
         S_SIGN: begin
            if (den_ff == '0) begin
               rn_in = '0; rd_in = RDEN_WIDTH'(1); st_in = 1'b1;
               state_in = S_DONE;
            end else begin
               neg_in = num_ff[RES_WIDTH-1] != den_ff[RES_WIDTH-1];
               nm_in = num_ff[RES_WIDTH-1] ? RES_WIDTH'(-num_ff) : num_ff;
               dm_in = den_ff[RES_WIDTH-1] ? RES_WIDTH'(-den_ff) : den_ff;
               x_in = num_ff[RES_WIDTH-1] ? RES_WIDTH'(-num_ff) : num_ff;
               y_in = den_ff[RES_WIDTH-1] ? RES_WIDTH'(-den_ff) : den_ff;
               state_in = S_GCD;
            end
         end
         S_GCD: begin
            // One remainder step per divider pass; x holds the GCD when y is zero.
            if (y_ff == '0) begin
               q_in = nm_ff; r_in = '0; dv_in = x_ff; cnt_in = '0;
               ret_in = S_DIVN;
               state_in = S_DIV;
            end else begin
               q_in = x_ff; r_in = '0; dv_in = y_ff; cnt_in = '0;
               ret_in = S_GCD;
               x_in = y_ff;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (!rsub[RES_WIDTH]) begin
               r_in = rsub[RES_WIDTH-1:0];
               q_in = {q_ff[RES_WIDTH-2:0], 1'b1};
            end else begin
               r_in = rsh[RES_WIDTH-1:0];
               q_in = {q_ff[RES_WIDTH-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CNT_WIDTH'(1);
            if (cnt_ff == CNT_WIDTH'(RES_WIDTH-1)) begin
               state_in = ret_ff;
               if (ret_ff == S_GCD) begin
                  y_in = r_in;
               end
            end
         end
         S_DIVN: begin
            nm_in = q_ff;
            q_in = dm_ff; r_in = '0; dv_in = x_ff; cnt_in = '0;
            ret_in = S_DIVD;
            state_in = S_DIV;
         end
         S_DIVD: begin
            st_in = 1'b0;
            if (nm_ff == '0) begin
               rn_in = '0; rd_in = RDEN_WIDTH'(1);
            end else begin
               rn_in = neg_ff ? RES_WIDTH'(-nm_ff) : nm_ff;
               rd_in = q_ff[RDEN_WIDTH-1:0];
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rv_ff) begin
               rv_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff <= S_IDLE;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
         rv_ff <= rv_in;
      end
      act_ff <= act_in; an_ff <= an_in; bn_ff <= bn_in; ad_ff <= ad_in;
      bd_ff <= bd_in; p_ff <= p_in; num_ff <= num_in; den_ff <= den_in;
      nm_ff <= nm_in; dm_ff <= dm_in; x_ff <= x_in; y_ff <= y_in;
      neg_ff <= neg_in; q_ff <= q_in; r_ff <= r_in; dv_ff <= dv_in;
      cnt_ff <= cnt_in; st_ff <= st_in; rn_ff <= rn_in; rd_ff <= rd_in;
   end

   assign req_stall = (state_ff != S_IDLE) || rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_result_numerator = rn_ff;
   assign rsp_result_denominator = rd_ff;
   assign rsp_status = st_ff;
endmodule
